// ===== hw/rtl/edw_pkg.sv =====
// shared types, constants and tables of the echo distance display writer
package edw_pkg;

   // display and bus sizing
   localparam int DIGITS      = 4;
   localparam int ACK_TIMEOUT = 100;
   localparam int ACK_WAIT_W  = 7;
   localparam int BYTE_IDX_W  = $clog2(DIGITS + 1);

   // field widths
   localparam int COUNT_W  = 16;
   localparam int DIST_W   = 11;
   localparam int SEG_W    = 8;
   localparam int BRIGHT_W = 3;

   // distance = count * 17 / 1000, done as ((count * 17) >> 3) / 125
   localparam int          TIMES17_W  = COUNT_W + 5;
   localparam int          SCALED_W   = TIMES17_W - 3;
   localparam logic [17:0] DIST_RECIP = 18'd134218;
   localparam int          DIST_SHIFT = 24;
   localparam int          DIST_MAX   = 1114;

   // reciprocals of powers of ten for the digit split, scaled by 2^32
   localparam int RECIP_SHIFT = 32;

   // bus command bytes
   localparam logic [7:0] CMD_DATA = 8'h40;
   localparam logic [7:0] CMD_ADDR = 8'hC0;
   localparam logic [7:0] CMD_CTRL = 8'h88;

   typedef logic [SEG_W-1:0] seg_type;
   typedef seg_type [DIGITS-1:0] digit_codes_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_ST_HI,
      PH_ST_LO,
      PH_BIT_LO,
      PH_BIT_HI,
      PH_ACK_REL,
      PH_ACK_WAIT,
      PH_ACK_HI,
      PH_ACK_LO,
      PH_SP_CLK,
      PH_SP_DIO,
      PH_SP_HI,
      PH_SP_END
   } phase_type;

   typedef enum logic [1:0] {
      FR_DATA,
      FR_ADDR,
      FR_CTRL
   } frame_type;

   typedef struct packed {
      logic               cmd;
      logic [COUNT_W-1:0] echo_count;
      logic               dio_in;
   } req_type;

   typedef struct packed {
      logic              clk_level;
      logic              dio_drive;
      logic              busy_res;
      seg_type           port_segments;
      logic [DIST_W-1:0] distance;
      logic              rejected;
      logic              ack_missing;
      logic              frame_done;
   } rsp_type;

   function automatic seg_type seg_of(input logic [3:0] digit);
      seg_type code;
      case (digit)
         4'd0: code = 8'h3f;
         4'd1: code = 8'h06;
         4'd2: code = 8'h5b;
         4'd3: code = 8'h4f;
         4'd4: code = 8'h66;
         4'd5: code = 8'h6d;
         4'd6: code = 8'h7d;
         4'd7: code = 8'h07;
         4'd8: code = 8'h7f;
         4'd9: code = 8'h6f;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   // power-on digit pattern, repeats every four digits
   function automatic seg_type reset_code(input int k);
      seg_type code;
      case (k % 4)
         0: code = 8'h3f;
         1: code = 8'h06;
         2: code = 8'h5f;
         default: code = 8'h38;
      endcase
      return code;
   endfunction

   // ceil(2^32 / 10^j), exact for quotients of values below 2^11
   function automatic logic [31:0] recip_of(input int j);
      logic [31:0] m;
      case (j)
         1: m = 32'd429496730;
         2: m = 32'd42949673;
         3: m = 32'd4294968;
         4: m = 32'd429497;
         5: m = 32'd42950;
         6: m = 32'd4295;
         default: m = 32'd0;
      endcase
      return m;
   endfunction

endpackage

// ===== hw/rtl/edw_dist.sv =====
// echo count to distance scaling, one multiply by a reciprocal
module edw_dist (
   input  logic [edw_pkg::COUNT_W-1:0] echo_count,
   output logic [edw_pkg::DIST_W-1:0]  dist_val
);
   import edw_pkg::*;

   logic [TIMES17_W-1:0]  times17;
   logic [2*SCALED_W-1:0] prod;

   always_comb begin
      times17  = {1'b0, echo_count, 4'b0000} + {5'b00000, echo_count};
      prod     = {{SCALED_W{1'b0}}, times17[TIMES17_W-1:3]} *
                 {{(2*SCALED_W-18){1'b0}}, DIST_RECIP};
      dist_val = prod[DIST_SHIFT +: DIST_W];
   end

endmodule

// ===== hw/rtl/edw_digits.sv =====
// decimal digit split of the distance and segment mapping
module edw_digits (
   input  logic [edw_pkg::DIST_W-1:0] dist_val,
   output edw_pkg::digit_codes_type   codes,
   output edw_pkg::seg_type           ones_code
);
   import edw_pkg::*;

   logic [DIST_W-1:0]             quot  [DIGITS+1];
   logic [DIST_W+RECIP_SHIFT-1:0] prod  [1:DIGITS];
   logic [DIST_W-1:0]             tenq  [DIGITS];
   logic [3:0]                    digit [DIGITS];

   always_comb begin
      quot[0] = dist_val;
      for (int j = 1; j <= DIGITS; j++) begin
         prod[j] = {{RECIP_SHIFT{1'b0}}, dist_val} * {{DIST_W{1'b0}}, recip_of(j)};
         quot[j] = prod[j][RECIP_SHIFT +: DIST_W];
      end
      // digit j is quot[j] minus ten times quot[j+1]
      for (int j = 0; j < DIGITS; j++) begin
         tenq[j]  = (quot[j+1] << 3) + (quot[j+1] << 1);
         digit[j] = 4'(quot[j] - tenq[j]);
      end
      ones_code = seg_of(digit[0]);
      // most significant digit sits at entry zero
      for (int k = 0; k < DIGITS; k++) begin
         codes[k] = seg_of(digit[DIGITS-1-k]);
      end
   end

endmodule

// ===== hw/rtl/edw_seq.sv =====
// two-wire display bus sequencer, one phase per tick beat except that the ack wait phase holds until ack or timeout
module edw_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  edw_pkg::req_type              req,
   input  logic [edw_pkg::DIST_W-1:0]    dist_val,
   input  edw_pkg::digit_codes_type      codes,
   input  edw_pkg::seg_type              ones_code,
   input  logic [edw_pkg::BRIGHT_W-1:0]  brightness,
   output edw_pkg::rsp_type              rsp
);
   import edw_pkg::*;

   phase_type             phase_ff, phase_in;
   frame_type             frame_ff, frame_in;
   logic [BYTE_IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [2:0]            bit_index_ff, bit_index_in;
   logic [7:0]            shift_byte_ff, shift_byte_in;
   logic [ACK_WAIT_W-1:0] ack_wait_ff, ack_wait_in;
   logic [DIST_W-1:0]     last_distance_ff, last_distance_in;
   seg_type               last_segments_ff, last_segments_in;
   logic                  clk_line_ff, clk_line_in;
   logic                  dio_line_ff, dio_line_in;
   digit_codes_type       digit_bytes_ff;

   logic                  take_digits;
   logic                  rejected, ack_missing, frame_done;
   logic [ACK_WAIT_W-1:0] ack_count_up;
   logic                  ack_timeout;
   logic                  more_digits;
   logic [BYTE_IDX_W-1:0] load_index;
   logic [7:0]            load_byte;

   always_comb begin
      ack_count_up = ack_wait_ff + 1'b1;
      ack_timeout  = ack_count_up >= ACK_WAIT_W'(ACK_TIMEOUT);
      more_digits  = (frame_ff == FR_ADDR) && (byte_index_ff < BYTE_IDX_W'(DIGITS));
      load_index   = (phase_ff == PH_ACK_LO) ? byte_index_ff + 1'b1 : byte_index_ff;
   end

   // byte that the next frame slot sends
   always_comb begin
      case (frame_ff)
         FR_DATA: load_byte = CMD_DATA;
         FR_ADDR: begin
            load_byte = CMD_ADDR;
            for (int k = 0; k < DIGITS; k++) begin
               if (load_index == BYTE_IDX_W'(k + 1)) begin
                  load_byte = digit_bytes_ff[k];
               end
            end
         end
         default: load_byte = CMD_CTRL | {{(8-BRIGHT_W){1'b0}}, brightness};
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (req.cmd) begin
         if (phase_ff == PH_IDLE) begin
            phase_in = PH_ST_HI;
         end
      end else begin
         case (phase_ff)
            PH_IDLE:     phase_in = PH_IDLE;
            PH_ST_HI:    phase_in = PH_ST_LO;
            PH_ST_LO:    phase_in = PH_BIT_LO;
            PH_BIT_LO:   phase_in = PH_BIT_HI;
            PH_BIT_HI:   phase_in = (bit_index_ff == 3'd7) ? PH_ACK_REL : PH_BIT_LO;
            PH_ACK_REL:  phase_in = PH_ACK_WAIT;
            PH_ACK_WAIT: begin
               if (!req.dio_in || ack_timeout) begin
                  phase_in = PH_ACK_HI;
               end
            end
            PH_ACK_HI:   phase_in = PH_ACK_LO;
            PH_ACK_LO:   phase_in = more_digits ? PH_BIT_LO : PH_SP_CLK;
            PH_SP_CLK:   phase_in = PH_SP_DIO;
            PH_SP_DIO:   phase_in = PH_SP_HI;
            PH_SP_HI:    phase_in = PH_SP_END;
            PH_SP_END:   phase_in = (frame_ff == FR_CTRL) ? PH_IDLE : PH_ST_HI;
            default:     phase_in = PH_IDLE;
         endcase
      end
   end

   // lines, counters and flags
   always_comb begin
      frame_in         = frame_ff;
      byte_index_in    = byte_index_ff;
      bit_index_in     = bit_index_ff;
      shift_byte_in    = shift_byte_ff;
      ack_wait_in      = ack_wait_ff;
      last_distance_in = last_distance_ff;
      last_segments_in = last_segments_ff;
      clk_line_in      = clk_line_ff;
      dio_line_in      = dio_line_ff;
      take_digits      = 1'b0;
      rejected         = 1'b0;
      ack_missing      = 1'b0;
      frame_done       = 1'b0;
      if (req.cmd) begin
         if (phase_ff != PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            take_digits      = 1'b1;
            last_distance_in = dist_val;
            last_segments_in = ones_code;
            frame_in         = FR_DATA;
            byte_index_in    = '0;
         end
      end else begin
         case (phase_ff)
            PH_ST_HI: begin
               clk_line_in = 1'b1;
               dio_line_in = 1'b1;
            end
            PH_ST_LO: begin
               dio_line_in   = 1'b0;
               shift_byte_in = load_byte;
               bit_index_in  = '0;
            end
            PH_BIT_LO: begin
               clk_line_in   = 1'b0;
               dio_line_in   = shift_byte_ff[0];
               shift_byte_in = shift_byte_ff >> 1;
            end
            PH_BIT_HI: begin
               clk_line_in = 1'b1;
               if (bit_index_ff != 3'd7) begin
                  bit_index_in = bit_index_ff + 1'b1;
               end
            end
            PH_ACK_REL: begin
               clk_line_in = 1'b0;
               dio_line_in = 1'b1;
               ack_wait_in = '0;
            end
            PH_ACK_WAIT: begin
               if (req.dio_in) begin
                  ack_wait_in = ack_count_up;
                  ack_missing = ack_timeout;
               end
            end
            PH_ACK_HI: clk_line_in = 1'b1;
            PH_ACK_LO: begin
               clk_line_in = 1'b0;
               if (more_digits) begin
                  byte_index_in = load_index;
                  shift_byte_in = load_byte;
                  bit_index_in  = '0;
               end
            end
            PH_SP_CLK: clk_line_in = 1'b0;
            PH_SP_DIO: dio_line_in = 1'b0;
            PH_SP_HI:  clk_line_in = 1'b1;
            PH_SP_END: begin
               dio_line_in   = 1'b1;
               byte_index_in = '0;
               case (frame_ff)
                  FR_DATA: frame_in = FR_ADDR;
                  FR_ADDR: frame_in = FR_CTRL;
                  default: begin
                     frame_in   = FR_DATA;
                     frame_done = 1'b1;
                  end
               endcase
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp.clk_level     = clk_line_in;
      rsp.dio_drive     = dio_line_in;
      rsp.busy_res      = phase_in != PH_IDLE;
      rsp.port_segments = last_segments_in;
      rsp.distance      = last_distance_in;
      rsp.rejected      = rejected;
      rsp.ack_missing   = ack_missing;
      rsp.frame_done    = frame_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         frame_ff         <= FR_DATA;
         byte_index_ff    <= '0;
         bit_index_ff     <= '0;
         shift_byte_ff    <= '0;
         ack_wait_ff      <= '0;
         last_distance_ff <= '0;
         last_segments_ff <= '0;
         clk_line_ff      <= 1'b1;
         dio_line_ff      <= 1'b1;
         for (int k = 0; k < DIGITS; k++) begin
            digit_bytes_ff[k] <= reset_code(k);
         end
      end else if (step) begin
         phase_ff         <= phase_in;
         frame_ff         <= frame_in;
         byte_index_ff    <= byte_index_in;
         bit_index_ff     <= bit_index_in;
         shift_byte_ff    <= shift_byte_in;
         ack_wait_ff      <= ack_wait_in;
         last_distance_ff <= last_distance_in;
         last_segments_ff <= last_segments_in;
         clk_line_ff      <= clk_line_in;
         dio_line_ff      <= dio_line_in;
         if (take_digits) begin
            digit_bytes_ff <= codes;
         end
      end
   end

endmodule

// ===== hw/rtl/echo_distance_display_writer.sv =====
// top level of the echo distance display writer
//
// each request beat is either one bus tick or a new echo measurement; every beat
// gives exactly one response beat with the clock and data line levels, busy, the
// latest distance (count * 17 / 1000) with its ones-digit segment code, and the
// rejected, ack-missing and frame-done flags. a measurement taken while a write
// is running is dropped and flagged. the block sustains one beat per clock while
// responses are taken: a request beat is registered, its distance is formed by
// one reciprocal multiply into a second register, and from there the digit split
// and the bus sequencer update their state and load the response register. the
// pipeline stalls only when the response is not taken. brightness is written
// through csr_wr_en and csr_wr_data and is used by the display control byte when
// it is next loaded
module echo_distance_display_writer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  edw_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output edw_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [edw_pkg::BRIGHT_W-1:0]  csr_wr_data
);
   import edw_pkg::*;

   // input stage
   logic              in_valid_ff;
   req_type           in_item_ff;
   // distance stage
   logic              mid_valid_ff;
   req_type           mid_item_ff;
   logic [DIST_W-1:0] mid_dist_ff;
   logic [DIST_W-1:0] dist_in;
   // response stage
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_in;

   logic [BRIGHT_W-1:0] brightness_ff;

   digit_codes_type codes;
   seg_type         ones_code;

   logic rsp_load;
   logic mid_load;

   // stage advance chain, back from the response side
   always_comb begin
      rsp_load  = mid_valid_ff && (!rsp_valid_ff || rsp_ready);
      mid_load  = in_valid_ff && (!mid_valid_ff || rsp_load);
      req_ready = !in_valid_ff || mid_load;
   end

   edw_dist u_dist (
      .echo_count (in_item_ff.echo_count),
      .dist_val   (dist_in)
   );

   edw_digits u_digits (
      .dist_val  (mid_dist_ff),
      .codes     (codes),
      .ones_code (ones_code)
   );

   // sequencer state moves only when the beat lands in the response register
   edw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (rsp_load),
      .req        (mid_item_ff),
      .dist_val   (mid_dist_ff),
      .codes      (codes),
      .ones_code  (ones_code),
      .brightness (brightness_ff),
      .rsp        (rsp_in)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (!mid_valid_ff || rsp_load) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= mid_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_data;
      end
      if (mid_load) begin
         mid_item_ff <= in_item_ff;
         mid_dist_ff <= dist_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // brightness register
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= '0;
      end else if (csr_wr_en) begin
         brightness_ff <= csr_wr_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // a dropped measurement leaves the write running
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.rejected |-> rsp_data_ff.busy_res)
      else $error("rejected beat without a write in progress");

   // the closing tick ends idle with both lines released
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_done |->
      !rsp_data_ff.busy_res && rsp_data_ff.clk_level && rsp_data_ff.dio_drive)
      else $error("frame done while bus not released");

   // a timed-out slot only happens on a tick inside a write
   a_ack_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.ack_missing |->
      rsp_data_ff.busy_res && !rsp_data_ff.rejected && !rsp_data_ff.frame_done)
      else $error("ack missing outside a write");

   // distance stays within the scaled count range
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.distance <= DIST_W'(DIST_MAX))
      else $error("distance out of range");
`endif

endmodule
